[src/spwm_pkg.sv]
// Shared constants, types and sine table builder for the sine PWM phase generator.
package spwm_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int STEP_BITS       = 31;
    localparam int SINE_TABLE_BITS = 10;
    localparam int DUTY_BITS       = 10;
    localparam int SINE_ENTRIES    = 1 << SINE_TABLE_BITS;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;

    localparam int SEL_BITS       = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = DUTY_BITS;

    // Phase selector codes
    localparam logic [SEL_BITS-1:0] PHASE_A = 2'd0;
    localparam logic [SEL_BITS-1:0] PHASE_B = 2'd1;
    localparam logic [SEL_BITS-1:0] PHASE_C = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_SELECT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_MIN     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_MAX     = 2'd2;

    localparam longint unsigned FULL_TURN  = 64'd1 << PHASE_BITS;
    localparam longint unsigned THIRD_TURN = (FULL_TURN + 64'd1) / 64'd3;
    localparam longint unsigned MINUS_THIRD_TURN = FULL_TURN - THIRD_TURN;
    localparam logic [PHASE_BITS-1:0] OFFSET_B = THIRD_TURN[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] OFFSET_C = MINUS_THIRD_TURN[PHASE_BITS-1:0];

    localparam logic [DUTY_BITS-1:0] DUTY_MIN_RESET = '0;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX_RESET = '1;

    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam longint unsigned DUTY_FULL = (64'd1 << DUTY_BITS) - 64'd1;
    localparam longint unsigned SIN_C1 = 64'd1686629713;
    localparam longint unsigned SIN_C3 = 64'd693598669;
    localparam longint unsigned SIN_C5 = 64'd85569305;
    localparam longint unsigned SIN_C7 = 64'd5026995;
    localparam longint unsigned SIN_C9 = 64'd172272;

    typedef logic [DUTY_BITS-1:0] sine_table_t [SINE_ENTRIES];

    // Q30 quarter-wave sine magnitude, truncating Horner evaluation on u^2
    function automatic longint unsigned quarter_sine(input longint unsigned u);
        longint unsigned u2;
        longint unsigned t;
        u2 = (u * u) >> 30;
        t  = SIN_C9;
        t  = SIN_C7 - ((t * u2) >> 30);
        t  = SIN_C5 - ((t * u2) >> 30);
        t  = SIN_C3 - ((t * u2) >> 30);
        t  = SIN_C1 - ((t * u2) >> 30);
        t  = (t * u) >> 30;
        if (t > Q30_ONE) begin
            t = Q30_ONE;
        end
        return t;
    endfunction

    // Unclamped duty for every table index, evaluated at elaboration
    function automatic sine_table_t build_sine_table();
        sine_table_t     tbl;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned m;
        longint unsigned num;
        longint unsigned v;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            quad = (longint'(k) >> QUARTER_BITS) & 64'd3;
            r    = longint'(k) & ((64'd1 << QUARTER_BITS) - 64'd1);
            if (quad[0]) begin
                r = (64'd1 << QUARTER_BITS) - r;
            end
            m   = quarter_sine(r << (30 - QUARTER_BITS));
            num = quad[1] ? (Q30_ONE - m) : (Q30_ONE + m);
            v   = (num * DUTY_FULL + Q30_ONE) >> 31;
            tbl[k] = v[DUTY_BITS-1:0];
        end
        return tbl;
    endfunction

endpackage

[src/spwm_phase_acc.sv]
// Phase accumulator with output phase offset and table address generation.
module spwm_phase_acc (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_load,
    input  logic [spwm_pkg::STEP_BITS-1:0]        phase_step,
    input  logic [spwm_pkg::SEL_BITS-1:0]         phase_select,
    output logic [spwm_pkg::SINE_TABLE_BITS-1:0]  table_addr
);
    import spwm_pkg::*;

    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] offset;
    logic [PHASE_BITS-1:0] out_phase;

    assign acc_next = acc_reg + PHASE_BITS'(phase_step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (step_load) begin
            acc_reg <= acc_next;
        end
    end

    // The offset touches only the output phase, never the stored one
    always_comb begin
        unique case (phase_select)
            PHASE_B: offset = OFFSET_B;
            PHASE_C: offset = OFFSET_C;
            default: offset = '0;
        endcase
    end

    assign out_phase  = acc_reg + offset;
    assign table_addr = out_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];

endmodule

[src/spwm_sine_rom.sv]
// Full-wave sine duty ROM with registered read data.
module spwm_sine_rom (
    input  logic                                 aclk,
    input  logic                                 rd_en,
    input  logic [spwm_pkg::SINE_TABLE_BITS-1:0] rd_addr,
    output logic [spwm_pkg::DUTY_BITS-1:0]       rd_data
);
    import spwm_pkg::*;

    localparam sine_table_t SINE_ROM = build_sine_table();

    logic [DUTY_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/spwm_clamp.sv]
// Duty clamp between the configured bounds into the output register.
module spwm_clamp (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [spwm_pkg::DUTY_BITS-1:0] raw_duty,
    input  logic [spwm_pkg::DUTY_BITS-1:0] duty_min,
    input  logic [spwm_pkg::DUTY_BITS-1:0] duty_max,
    output logic [spwm_pkg::DUTY_BITS-1:0] duty
);
    import spwm_pkg::*;

    logic [DUTY_BITS-1:0] lo_clamped;
    logic [DUTY_BITS-1:0] duty_next;
    logic [DUTY_BITS-1:0] duty_reg;

    // Upper bound applied last, so it wins when the bounds cross
    assign lo_clamped = (raw_duty < duty_min) ? duty_min : raw_duty;
    assign duty_next  = (lo_clamped > duty_max) ? duty_max : lo_clamped;

    always_ff @(posedge aclk) begin
        if (load) begin
            duty_reg <= duty_next;
        end
    end

    assign duty = duty_reg;

endmodule

[src/sine_pwm_phase_generator.sv]
// A result passes the accumulator, the ROM read register and the output register, in that order.
// Throughput: one transaction per cycle; a stalled result stalls the whole three-stage pipe.
// The ROM read port and the output register set the stage boundaries.
// Reset (synchronous, aresetn low): accumulator zero, pipe empty, phase A, duty bounds 0..1023.
// No clearing pass: the sine ROM is constant.
module sine_pwm_phase_generator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,   // [30:0] phase_step
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [9:0] duty
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spwm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [spwm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import spwm_pkg::*;

    logic                       pipe_en;
    logic                       s_accept;
    logic                       acc_valid_reg;
    logic                       rom_valid_reg;
    logic                       out_valid_reg;
    logic [SEL_BITS-1:0]        phase_select_reg;
    logic [DUTY_BITS-1:0]       duty_min_reg;
    logic [DUTY_BITS-1:0]       duty_max_reg;
    logic [SINE_TABLE_BITS-1:0] table_addr;
    logic [DUTY_BITS-1:0]       raw_duty;
    logic [DUTY_BITS-1:0]       duty;

    // Advance every stage together unless the result register is held
    assign pipe_en   = !out_valid_reg || m_tready;
    assign s_tready  = pipe_en;
    assign s_accept  = s_tvalid && pipe_en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_select_reg <= PHASE_A;
            duty_min_reg     <= DUTY_MIN_RESET;
            duty_max_reg     <= DUTY_MAX_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PHASE_SELECT: phase_select_reg <= cfg_data[SEL_BITS-1:0];
                CFG_DUTY_MIN:     duty_min_reg     <= cfg_data[DUTY_BITS-1:0];
                CFG_DUTY_MAX:     duty_max_reg     <= cfg_data[DUTY_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
            rom_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            acc_valid_reg <= s_tvalid;
            rom_valid_reg <= acc_valid_reg;
            out_valid_reg <= rom_valid_reg;
        end
    end

    spwm_phase_acc u_phase_acc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_load    (s_accept),
        .phase_step   (s_tdata[STEP_BITS-1:0]),
        .phase_select (phase_select_reg),
        .table_addr   (table_addr)
    );

    spwm_sine_rom u_sine_rom (
        .aclk    (aclk),
        .rd_en   (pipe_en),
        .rd_addr (table_addr),
        .rd_data (raw_duty)
    );

    spwm_clamp u_clamp (
        .aclk     (aclk),
        .load     (pipe_en),
        .raw_duty (raw_duty),
        .duty_min (duty_min_reg),
        .duty_max (duty_max_reg),
        .duty     (duty)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(16 - DUTY_BITS)'(0), duty};

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the sine PWM phase generator: stream driver, result monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spwm_pkg::*;

    localparam logic [SEL_BITS-1:0] PHASE_UNUSED = 2'd3;
    localparam logic [30:0]         QUARTER_STEP = 31'h40000000;
    localparam logic [31:0]         THIRD_OF_TURN = 32'd1431655765;
    localparam int                  HOLD_CYCLES  = 400;
    localparam int                  STALL_LIMIT  = 4000;

    // Q30 Taylor coefficients of sin(pi*u/2), odd terms
    localparam longint unsigned Q_ONE = 64'd1073741824;
    localparam longint unsigned K1    = 64'd1686629713;
    localparam longint unsigned K3    = 64'd693598669;
    localparam longint unsigned K5    = 64'd85569305;
    localparam longint unsigned K7    = 64'd5026995;
    localparam longint unsigned K9    = 64'd172272;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // predictor state and its copy of the registers
    logic [31:0]          phase_acc    = '0;
    logic [SEL_BITS-1:0]  out_phase    = PHASE_A;
    logic [DUTY_BITS-1:0] duty_floor   = '0;
    logic [DUTY_BITS-1:0] duty_ceiling = '1;

    logic [30:0]          step_q [$];
    logic [DUTY_BITS-1:0] duty_q [$];
    logic [DUTY_BITS-1:0] want_duty;

    bit no_gaps  = 1'b0;
    bit hold_req = 1'b0;
    int hold_left    = 0;
    int stall_cycles = 0;
    int errors       = 0;

    sine_pwm_phase_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // offset the accumulator, look up (sin+1)/2 scaled to duty, clamp
    function automatic logic [DUTY_BITS-1:0] expected_duty(input logic [31:0] acc);
        logic [31:0]     ph;
        logic [9:0]      idx;
        longint unsigned frac;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned poly;
        longint unsigned num;
        longint unsigned scaled;
        logic [DUTY_BITS-1:0] v;
        case (out_phase)
            PHASE_B: ph = acc + THIRD_OF_TURN;
            PHASE_C: ph = acc - THIRD_OF_TURN;
            default: ph = acc;
        endcase
        idx  = ph[31:22];
        frac = 64'(idx[7:0]);
        if (idx[8]) begin
            frac = 64'd256 - frac;
        end
        x    = frac << 22;
        x2   = (x * x) >> 30;
        poly = K9;
        poly = K7 - ((poly * x2) >> 30);
        poly = K5 - ((poly * x2) >> 30);
        poly = K3 - ((poly * x2) >> 30);
        poly = K1 - ((poly * x2) >> 30);
        poly = (poly * x) >> 30;
        if (poly > Q_ONE) begin
            poly = Q_ONE;
        end
        num    = idx[9] ? (Q_ONE - poly) : (Q_ONE + poly);
        scaled = (num * 64'd1023 + Q_ONE) >> 31;
        v      = scaled[DUTY_BITS-1:0];
        if (v < duty_floor) begin
            v = duty_floor;
        end
        if (v > duty_ceiling) begin
            v = duty_ceiling;
        end
        return v;
    endfunction

    // sender: predict on each accepted transaction, then offer the next step
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            phase_acc = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                phase_acc = phase_acc + {1'b0, s_tdata[30:0]};
                duty_q.push_back(expected_duty(phase_acc));
            end
            if (!s_tvalid || s_tready) begin
                if (step_q.size() > 0 && (no_gaps || $urandom_range(99) >= 17)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, step_q.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result, stall at random or for a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (duty_q.size() == 0) begin
                    $error("duty: no result expected, actual %0d", m_tdata[DUTY_BITS-1:0]);
                    errors++;
                end else begin
                    want_duty = duty_q.pop_front();
                    if (m_tdata[DUTY_BITS-1:0] !== want_duty) begin
                        $error("duty: expected %0d, actual %0d",
                               want_duty, m_tdata[DUTY_BITS-1:0]);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PHASE_SELECT: out_phase    = val[SEL_BITS-1:0];
            CFG_DUTY_MIN:     duty_floor   = val;
            CFG_DUTY_MAX:     duty_ceiling = val;
            default: ;
        endcase
    endtask

    // hold the stimulus until every offered step is accepted and every result is back
    task automatic wait_idle();
        do @(negedge aclk); while (step_q.size() > 0 || s_tvalid || duty_q.size() > 0);
    endtask

    initial begin : stimulus
        logic [SEL_BITS-1:0]  sel_w;
        logic [DUTY_BITS-1:0] lo_w;
        logic [DUTY_BITS-1:0] hi_w;
        logic [7:0]           upper_w;
        logic [30:0]          step;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes, quarter turns, wrap and single table steps at reset settings
        step_q.push_back(31'd0);
        repeat (4) step_q.push_back(QUARTER_STEP);
        step_q.push_back(31'd1);
        step_q.push_back(31'h7FFFFFFF);
        step_q.push_back(31'h7FFFFFFF);
        step_q.push_back(31'h3FFFFFFF);
        step_q.push_back(31'h00400000);
        step_q.push_back(31'h003FFFFF);
        step_q.push_back(31'h2AAAAAAA);
        step_q.push_back(31'h55555555);
        wait_idle();

        for (int p = 1; p <= 10; p++) begin
            upper_w = '0;
            case (p)
                1: begin sel_w = PHASE_B;      lo_w = 10'd0;    hi_w = 10'd1023; end
                2: begin sel_w = PHASE_C;      lo_w = 10'd100;  hi_w = 10'd900;  end
                3: begin sel_w = PHASE_UNUSED; lo_w = 10'd1023; hi_w = 10'd1023; end
                4: begin sel_w = PHASE_A;      lo_w = 10'd600;  hi_w = 10'd300;  end
                5: begin sel_w = PHASE_B;      lo_w = 10'd0;    hi_w = 10'd0;    end
                default: begin
                    sel_w   = SEL_BITS'($urandom_range(3));
                    upper_w = 8'($urandom_range(255));
                    lo_w    = ($urandom_range(3) == 0) ? 10'd0 : 10'($urandom_range(1023));
                    hi_w    = ($urandom_range(3) == 0) ? 10'd1023 : 10'($urandom_range(1023));
                end
            endcase
            write_reg(CFG_PHASE_SELECT, {upper_w, sel_w});
            write_reg(CFG_DUTY_MIN, lo_w);
            write_reg(CFG_DUTY_MAX, hi_w);
            @(negedge aclk);
            no_gaps = (p == 3);
            // long receiver hold-off while the sender keeps offering
            if (p == 1) begin
                hold_req = 1'b1;
            end
            repeat (4) step_q.push_back(QUARTER_STEP);
            repeat (166) begin
                case ($urandom_range(3))
                    0: step = 31'($urandom());
                    1: step = 31'($urandom_range(32'h00FFFFFF));
                    2: step = 31'h7FFFFFFF - 31'($urandom_range(255));
                    default: step = 31'($urandom_range(511) << 22);
                endcase
                step_q.push_back(step);
            end
            wait_idle();
        end

        no_gaps = 1'b0;
        repeat (10) @(posedge aclk);
        if (errors == 0 && duty_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
